// ----- rtl/irn_pkg.sv -----
// irn_pkg: shared types, numeral tables and the microprogram ROM for the
// integer-to-Roman encoder. No dependencies.
`default_nettype none

package irn_pkg;

	localparam int unsigned ValueW  = 12;
	localparam int unsigned LetterW = 8;
	localparam int unsigned WeightW = 10;
	localparam int unsigned TableLen = 13;
	localparam int unsigned IdxW    = $clog2(TableLen);
	localparam int unsigned PcW     = 3;
	localparam logic [ValueW-1:0] RomanMax = ValueW'(3999);

	// datapath action of one microstep
	typedef enum logic [2:0] {
		ACT_NOP,
		ACT_LOAD,
		ACT_INCK,
		ACT_LEAD,
		ACT_TAIL,
		ACT_ERR
	} act_t;

	// branch condition; taken -> target, else fall through
	typedef enum logic [2:0] {
		CND_ALWAYS,
		CND_BAD,
		CND_GE,
		CND_SINGLE,
		CND_NZERO
	} cond_t;

	typedef struct packed {
		act_t           act;
		cond_t          cond;
		logic [PcW-1:0] target;
	} ucode_t;

	// sequencer -> datapath
	typedef struct packed {
		act_t act;
		logic fire;
	} irn_ctl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic bad;
		logic ge;
		logic single;
		logic nzero;
		logic out_free;
	} irn_sts_t;

	// step addresses
	localparam logic [PcW-1:0] StFetch = 3'd0;
	localparam logic [PcW-1:0] StScan  = 3'd1;
	localparam logic [PcW-1:0] StNext  = 3'd2;
	localparam logic [PcW-1:0] StLead  = 3'd3;
	localparam logic [PcW-1:0] StTail  = 3'd4;
	localparam logic [PcW-1:0] StCheck = 3'd5;
	localparam logic [PcW-1:0] StRet   = 3'd6;
	localparam logic [PcW-1:0] StErr   = 3'd7;

	function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
		ucode_t w;
		unique case (pc)
			StFetch: w = '{act: ACT_LOAD, cond: CND_BAD,    target: StErr};
			StScan:  w = '{act: ACT_NOP,  cond: CND_GE,     target: StLead};
			StNext:  w = '{act: ACT_INCK, cond: CND_ALWAYS, target: StScan};
			StLead:  w = '{act: ACT_LEAD, cond: CND_SINGLE, target: StCheck};
			StTail:  w = '{act: ACT_TAIL, cond: CND_ALWAYS, target: StCheck};
			StCheck: w = '{act: ACT_NOP,  cond: CND_NZERO,  target: StScan};
			StRet:   w = '{act: ACT_NOP,  cond: CND_ALWAYS, target: StFetch};
			StErr:   w = '{act: ACT_ERR,  cond: CND_ALWAYS, target: StFetch};
			default: w = '{act: ACT_NOP,  cond: CND_ALWAYS, target: StFetch};
		endcase
		return w;
	endfunction

	function automatic logic [WeightW-1:0] weight(input logic [IdxW-1:0] k);
		logic [WeightW-1:0] w;
		case (k)
			4'd0:    w = 10'd1000;
			4'd1:    w = 10'd900;
			4'd2:    w = 10'd500;
			4'd3:    w = 10'd400;
			4'd4:    w = 10'd100;
			4'd5:    w = 10'd90;
			4'd6:    w = 10'd50;
			4'd7:    w = 10'd40;
			4'd8:    w = 10'd10;
			4'd9:    w = 10'd9;
			4'd10:   w = 10'd5;
			4'd11:   w = 10'd4;
			default: w = 10'd1;
		endcase
		return w;
	endfunction

	function automatic logic [LetterW-1:0] lead_ch(input logic [IdxW-1:0] k);
		logic [LetterW-1:0] c;
		case (k) inside
			4'd0:                    c = "M";
			4'd1, 4'd3, 4'd4:        c = "C";
			4'd2:                    c = "D";
			4'd5, 4'd7, 4'd8:        c = "X";
			4'd6:                    c = "L";
			4'd10:                   c = "V";
			default:                 c = "I";
		endcase
		return c;
	endfunction

	// second letter of a subtractive pair
	function automatic logic [LetterW-1:0] tail_ch(input logic [IdxW-1:0] k);
		logic [LetterW-1:0] c;
		case (k)
			4'd1:    c = "M";
			4'd3:    c = "D";
			4'd5:    c = "C";
			4'd7:    c = "L";
			4'd9:    c = "X";
			default: c = "V";
		endcase
		return c;
	endfunction

	function automatic logic is_pair(input logic [IdxW-1:0] k);
		return (k == 4'd1) || (k == 4'd3) || (k == 4'd5) || (k == 4'd7) ||
			(k == 4'd9) || (k == 4'd11);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/irn_useq.sv -----
// irn_useq: microprogram step counter, ROM fetch and branch logic.
// Depends on irn_pkg.
`default_nettype none

module irn_useq
	import irn_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire irn_sts_t sts,
	output irn_ctl_t      ctl
);

	logic [PcW-1:0] pc_q;
	ucode_t         uw;
	logic           go;
	logic           taken;

	assign uw = ucode_rom(pc_q);

	// a step holds until its handshake side is free
	always_comb begin
		case (uw.act) inside
			ACT_LOAD:                    go = in_valid;
			ACT_LEAD, ACT_TAIL, ACT_ERR: go = sts.out_free;
			default:                     go = 1'b1;
		endcase
	end

	always_comb begin
		unique case (uw.cond)
			CND_ALWAYS: taken = 1'b1;
			CND_BAD:    taken = sts.bad;
			CND_GE:     taken = sts.ge;
			CND_SINGLE: taken = sts.single;
			CND_NZERO:  taken = sts.nzero;
			default:    taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= StFetch;
		end else if (go) begin
			pc_q <= taken ? uw.target : pc_q + PcW'(1);
		end
	end

	assign ctl.act  = uw.act;
	assign ctl.fire = go;

endmodule

`default_nettype wire

// ----- rtl/irn_dpath.sv -----
// irn_dpath: remainder and table index registers, compare/subtract, and the
// output beat register. Depends on irn_pkg.
`default_nettype none

module irn_dpath
	import irn_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire irn_ctl_t           ctl,
	input  wire logic [ValueW-1:0]  value,
	input  wire logic               out_ready,
	output irn_sts_t                sts,
	output logic                    out_valid,
	output logic [LetterW-1:0]      letter,
	output logic                    last,
	output logic                    bad
);

	logic [ValueW-1:0]  rest_q;
	logic [IdxW-1:0]    k_q;
	logic               out_valid_q;
	logic [LetterW-1:0] letter_q;
	logic               last_q;
	logic               bad_q;

	logic [ValueW-1:0]  w_ext;
	logic [ValueW-1:0]  diff;
	logic               pair;
	logic               emit;

	assign w_ext = {{(ValueW - WeightW){1'b0}}, weight(k_q)};
	assign diff  = rest_q - w_ext;
	assign pair  = is_pair(k_q);
	assign emit  = ctl.fire &&
		(ctl.act == ACT_LEAD || ctl.act == ACT_TAIL || ctl.act == ACT_ERR);

	assign sts.bad      = (value == '0) || (value > RomanMax);
	assign sts.ge       = rest_q >= w_ext;
	assign sts.single   = !pair;
	assign sts.nzero    = rest_q != '0;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			case (ctl.act)
				ACT_LOAD: begin
					rest_q <= value;
					k_q    <= '0;
				end
				ACT_INCK: k_q <= k_q + IdxW'(1);
				ACT_LEAD: if (!pair) rest_q <= diff;
				ACT_TAIL: rest_q <= diff;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			case (ctl.act)
				ACT_LEAD: begin
					letter_q <= lead_ch(k_q);
					last_q   <= !pair && (diff == '0);
					bad_q    <= 1'b0;
				end
				ACT_TAIL: begin
					letter_q <= tail_ch(k_q);
					last_q   <= diff == '0;
					bad_q    <= 1'b0;
				end
				default: begin
					letter_q <= '0;
					last_q   <= 1'b1;
					bad_q    <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign letter    = letter_q;
	assign last      = last_q;
	assign bad       = bad_q;

endmodule

`default_nettype wire

// ----- rtl/integer_to_roman_encoder.sv -----
// integer_to_roman_encoder: top level, microcoded Roman numeral encoder.
// Depends on irn_pkg, irn_useq, irn_dpath.
//
//   channel | signals                         | beat
//   --------+---------------------------------+---------------------------------
//   in      | in_valid, in_ready, value[11:0] | one number to convert
//   out     | out_valid, out_ready,           | one ASCII letter; last marks the
//           | letter[7:0], last, bad          | end of a numeral, bad an error
//
// Steps: an eight-step microprogram walks the 13-entry weight table. Per
// number: fetch, return, scan and next per table entry left behind (at most
// 12), scan, emit and check per single letter, and scan, emit, tail and check
// per subtractive pair. An error runs fetch and the error step.
// Reset: arst_n returns the step counter to fetch and empties the output beat.
// Stalls: an emit step waits while the output register holds an untaken beat;
// in_ready is high only in the fetch step, which may overlap a waiting beat.
`default_nettype none

module integer_to_roman_encoder
	import irn_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [ValueW-1:0]  value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [LetterW-1:0]      letter,
	output logic                    last,
	output logic                    bad
);

	irn_ctl_t ctl;
	irn_sts_t sts;

	// sequencer: step counter + control ROM
	irn_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.ctl      (ctl)
	);

	// datapath: remainder, table index, output register
	irn_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.value     (value),
		.out_ready (out_ready),
		.sts       (sts),
		.out_valid (out_valid),
		.letter    (letter),
		.last      (last),
		.bad       (bad)
	);

	// input is taken only in the fetch step
	assign in_ready = (ctl.act == ACT_LOAD);

endmodule

`default_nettype wire
